// ===== rtl/bmhq_pkg.sv =====
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared types and codes for the binary min-heap queue.
// ----------------------------------------------------------------------------
package bmhq_pkg;

  // Item kinds on the request channel
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP_READ,
    ST_UP_CMP,
    ST_DN_ROOT,
    ST_DN_READ,
    ST_DN_CMP,
    ST_FINISH
  } state_t;

  // Memory port strobes from the sequencer
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

// ===== rtl/bmhq_in_if.sv =====
// ----------------------------------------------------------------------------
// bmhq_in_if
// Request channel: insert or remove transactions with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bmhq_in_if #(
  parameter int KEY_BITS    = 32,
  parameter int HANDLE_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic                   kind;
  logic [KEY_BITS-1:0]    key;
  logic [HANDLE_BITS-1:0] node_handle;

  modport source (output valid, kind, key, node_handle, input ready);
  modport sink   (input valid, kind, key, node_handle, output ready);
endinterface

// ===== rtl/bmhq_out_if.sv =====
// ----------------------------------------------------------------------------
// bmhq_out_if
// Result channel: one transaction per request, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bmhq_out_if #(
  parameter int KEY_BITS    = 32,
  parameter int HANDLE_BITS = 16,
  parameter int COUNT_BITS  = 9
);
  logic                   valid;
  logic                   ready;
  logic [HANDLE_BITS-1:0] out_handle;
  logic [KEY_BITS-1:0]    out_key;
  logic [1:0]             status;
  logic [COUNT_BITS-1:0]  count;

  modport source (output valid, out_handle, out_key, status, count, input ready);
  modport sink   (input valid, out_handle, out_key, status, count, output ready);
endinterface

// ===== rtl/bmhq_mem.sv =====
// ----------------------------------------------------------------------------
// bmhq_mem
// Heap entry store: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module bmhq_mem
  import bmhq_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int WIDTH = 48,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  mem_ctl_t         ctl,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr_a,
  input  logic [AW-1:0]    rd_addr_b,
  output logic [WIDTH-1:0] rd_data_a,
  output logic [WIDTH-1:0] rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

// ===== rtl/bmhq_ctrl.sv =====
// ----------------------------------------------------------------------------
// bmhq_ctrl
// Sift sequencer: holds the moving entry in a register and walks the tree
// through the entry store, writing displaced entries into the hole.
// ----------------------------------------------------------------------------
module bmhq_ctrl
  import bmhq_pkg::*;
#(
  parameter int CAPACITY    = 256,
  parameter int KEY_BITS    = 32,
  parameter int HANDLE_BITS = 16,
  localparam int AW         = $clog2(CAPACITY),
  localparam int CW         = $clog2(CAPACITY + 1),
  localparam int EW         = KEY_BITS + HANDLE_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  bmhq_in_if.sink                req,
  // result toward the output register
  output logic                   res_valid,
  input  logic                   res_ready,
  output logic [KEY_BITS-1:0]    res_key,
  output logic [HANDLE_BITS-1:0] res_handle,
  output status_t                res_status,
  output logic [CW-1:0]          count,
  // entry store
  output mem_ctl_t               mem_ctl,
  output logic [AW-1:0]          wr_addr,
  output logic [EW-1:0]          wr_data,
  output logic [AW-1:0]          rd_addr_a,
  output logic [AW-1:0]          rd_addr_b,
  input  logic [EW-1:0]          rd_data_a,
  input  logic [EW-1:0]          rd_data_b
);

  // child indexes reach 2*CAPACITY, so they carry two more bits than an address
  localparam int IW = AW + 2;
  localparam logic [CW-1:0] CapCount = CW'(CAPACITY);

  state_t                 state, state_next;
  logic [CW-1:0]          count_next;
  logic [AW-1:0]          pos, pos_next;
  logic [AW-1:0]          par, par_next;
  logic [IW-1:0]          left, left_next;
  logic [IW-1:0]          right, right_next;
  logic [EW-1:0]          cur, cur_next;
  logic [KEY_BITS-1:0]    res_key_next;
  logic [HANDLE_BITS-1:0] res_handle_next;
  status_t                res_status_next;

  logic                   acc;
  logic [AW-1:0]          parent_idx;
  logic [IW-1:0]          left_idx;
  logic [IW-1:0]          right_idx;
  logic [IW-1:0]          count_wide;
  logic [KEY_BITS-1:0]    cur_key, key_a, key_b, pick_key;
  logic                   take_right;
  logic [EW-1:0]          pick;
  logic [AW-1:0]          pick_idx;

  assign acc        = req.valid && req.ready;
  assign req.ready  = (state == ST_IDLE);
  assign parent_idx = (pos - AW'(1)) >> 1;
  assign left_idx   = {1'b0, pos, 1'b1};
  assign right_idx  = left_idx + IW'(1);
  assign count_wide = IW'(count);
  assign cur_key    = cur[EW-1:HANDLE_BITS];
  assign key_a      = rd_data_a[EW-1:HANDLE_BITS];
  assign key_b      = rd_data_b[EW-1:HANDLE_BITS];
  // right child wins only when it exists and is strictly smaller
  assign take_right = (right < count_wide) && (key_b < key_a);
  assign pick       = take_right ? rd_data_b : rd_data_a;
  assign pick_idx   = take_right ? right[AW-1:0] : left[AW-1:0];
  assign pick_key   = pick[EW-1:HANDLE_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    pos        <= pos_next;
    par        <= par_next;
    left       <= left_next;
    right      <= right_next;
    cur        <= cur_next;
    res_key    <= res_key_next;
    res_handle <= res_handle_next;
    res_status <= res_status_next;
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    pos_next        = pos;
    par_next        = par;
    left_next       = left;
    right_next      = right;
    cur_next        = cur;
    res_key_next    = res_key;
    res_handle_next = res_handle;
    res_status_next = res_status;
    mem_ctl         = '0;
    wr_addr         = pos;
    wr_data         = cur;
    rd_addr_a       = '0;
    rd_addr_b       = '0;
    res_valid       = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (acc) begin
          res_key_next    = '0;
          res_handle_next = '0;
          res_status_next = STATUS_OK;
          if (req.kind == KIND_INSERT) begin
            if (count == CapCount) begin
              res_status_next = STATUS_FULL;
              state_next      = ST_FINISH;
            end else begin
              cur_next   = {req.key, req.node_handle};
              pos_next   = count[AW-1:0];
              count_next = count + CW'(1);
              state_next = ST_UP_READ;
            end
          end else begin
            if (count == '0) begin
              res_status_next = STATUS_EMPTY;
              state_next      = ST_FINISH;
            end else begin
              // fetch root and last entry together
              mem_ctl.rd_en = 1'b1;
              rd_addr_a     = '0;
              rd_addr_b     = AW'(count - CW'(1));
              count_next    = count - CW'(1);
              state_next    = ST_DN_ROOT;
            end
          end
        end
      end

      ST_UP_READ: begin
        if (pos == '0) begin
          mem_ctl.wr_en = 1'b1;
          state_next    = ST_FINISH;
        end else begin
          mem_ctl.rd_en = 1'b1;
          rd_addr_a     = parent_idx;
          par_next      = parent_idx;
          state_next    = ST_UP_CMP;
        end
      end

      ST_UP_CMP: begin
        mem_ctl.wr_en = 1'b1;
        if (cur_key < key_a) begin
          // move parent down into the hole, climb
          wr_data    = rd_data_a;
          pos_next   = par;
          state_next = ST_UP_READ;
        end else begin
          state_next = ST_FINISH;
        end
      end

      ST_DN_ROOT: begin
        res_key_next    = key_a;
        res_handle_next = rd_data_a[HANDLE_BITS-1:0];
        cur_next        = rd_data_b;
        pos_next        = '0;
        state_next      = (count == '0) ? ST_FINISH : ST_DN_READ;
      end

      ST_DN_READ: begin
        if (left_idx >= count_wide) begin
          mem_ctl.wr_en = 1'b1;
          state_next    = ST_FINISH;
        end else begin
          mem_ctl.rd_en = 1'b1;
          rd_addr_a     = left_idx[AW-1:0];
          rd_addr_b     = right_idx[AW-1:0];
          left_next     = left_idx;
          right_next    = right_idx;
          state_next    = ST_DN_CMP;
        end
      end

      ST_DN_CMP: begin
        mem_ctl.wr_en = 1'b1;
        if (cur_key <= pick_key) begin
          state_next = ST_FINISH;
        end else begin
          // move smaller child up into the hole, descend
          wr_data    = pick;
          pos_next   = pick_idx;
          state_next = ST_DN_READ;
        end
      end

      ST_FINISH: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CapCount)
    else $error("entry count above capacity");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !acc |=> $stable(count))
    else $error("entry count moved without a transaction");

  a_remove_fetch: assert property (@(posedge clk) disable iff (rst)
    (acc && req.kind == KIND_REMOVE && count != '0) |=> state == ST_DN_ROOT)
    else $error("remove did not fetch the root");

  a_write_state: assert property (@(posedge clk) disable iff (rst)
    mem_ctl.wr_en |-> (state == ST_UP_READ || state == ST_UP_CMP ||
                       state == ST_DN_READ || state == ST_DN_CMP))
    else $error("store write outside a sift");

  a_result_done: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_ready) |=> state == ST_IDLE)
    else $error("sequencer did not return to idle after result");
`endif

endmodule

// ===== rtl/binary_min_heap_queue.sv =====
// ----------------------------------------------------------------------------
// binary_min_heap_queue
// Array-based binary min-heap of (key, handle) entries with insert/remove.
// ----------------------------------------------------------------------------
// One request transaction at a time. An insert places its entry at the end
// of the heap and climbs: at each level it reads the parent, compares, and
// moves the parent down into the hole while the new key is smaller. A
// remove fetches the root and the last entry together, takes the root as
// the result and descends with the last entry: at each level it reads both
// children, compares, and moves the smaller child up into the hole while
// that child is smaller than the moving entry. A remove on an empty heap or
// a dropped insert on a full heap goes straight to the result. The next
// request is taken in the cycle after the result leaves the sequencer. Each
// level of the sift is one read of the entry store (registered read data)
// followed by a compare and a single write-back. The moving entry stays in
// a register during the sift and displaced entries are written into the
// hole, so every level costs one write instead of a swap. A request is
// taken while the previous result still waits in the output register; that
// request completes its sift and then holds until the output register frees.
// No clearing pass after reset: only positions below the entry count ever affect a result.
// ----------------------------------------------------------------------------
module binary_min_heap_queue
  import bmhq_pkg::*;
#(
  parameter int CAPACITY    = 256,
  parameter int KEY_BITS    = 32,
  parameter int HANDLE_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  bmhq_in_if.sink   req,
  bmhq_out_if.source rsp
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = KEY_BITS + HANDLE_BITS;

  // Sequencer to output register
  logic                   res_valid;
  logic                   res_ready;
  logic [KEY_BITS-1:0]    res_key;
  logic [HANDLE_BITS-1:0] res_handle;
  status_t                res_status;
  logic [CW-1:0]          count;

  // Sequencer to entry store
  mem_ctl_t               mem_ctl;
  logic [AW-1:0]          wr_addr;
  logic [EW-1:0]          wr_data;
  logic [AW-1:0]          rd_addr_a;
  logic [AW-1:0]          rd_addr_b;
  logic [EW-1:0]          rd_data_a;
  logic [EW-1:0]          rd_data_b;

  // Sift sequencer: owns the entry count, the moving entry and the walk
  bmhq_ctrl #(
    .CAPACITY    (CAPACITY),
    .KEY_BITS    (KEY_BITS),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_key    (res_key),
    .res_handle (res_handle),
    .res_status (res_status),
    .count      (count),
    .mem_ctl    (mem_ctl),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_addr_a  (rd_addr_a),
    .rd_addr_b  (rd_addr_b),
    .rd_data_a  (rd_data_a),
    .rd_data_b  (rd_data_b)
  );

  // Entry store: {key, handle} per heap position; second read port serves
  // the right child during sift-down and the last entry on remove
  bmhq_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (EW)
  ) u_mem (
    .clk       (clk),
    .ctl       (mem_ctl),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  // Output register: load when empty or draining this cycle, so a waiting
  // result never blocks the sequencer from accepting the next request
  assign res_ready = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  // Payload: hold while stalled, advance on load
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      rsp.out_key    <= res_key;
      rsp.out_handle <= res_handle;
      rsp.status     <= res_status;
      rsp.count      <= count;
    end
  end

endmodule

// ===== dv/bmhq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmhq_checker
// Watches both heap channels and predicts each result from a private heap
// model. Compares every result field by field and counts mismatches.
// ----------------------------------------------------------------------------
module bmhq_checker
  import bmhq_pkg::*;
#(
  parameter int CAPACITY    = 256,
  parameter int KEY_BITS    = 32,
  parameter int HANDLE_BITS = 16,
  parameter int COUNT_BITS  = 9
) (
  input  logic clk,
  input  logic rst,
  bmhq_in_if   req,
  bmhq_out_if  rsp,
  output int   mismatches,
  output int   awaiting
);

  typedef struct packed {
    logic [HANDLE_BITS-1:0] handle;
    logic [KEY_BITS-1:0]    key;
    status_t                status;
    logic [COUNT_BITS-1:0]  count;
  } heap_result_t;

  logic [KEY_BITS-1:0]    heap_key    [CAPACITY];
  logic [HANDLE_BITS-1:0] heap_handle [CAPACITY];
  int unsigned            heap_size;
  heap_result_t           pending_results [$];

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  function automatic void swap_slots(input int unsigned a, input int unsigned b);
    logic [KEY_BITS-1:0]    tk;
    logic [HANDLE_BITS-1:0] th;
    tk = heap_key[a];
    th = heap_handle[a];
    heap_key[a]    = heap_key[b];
    heap_handle[a] = heap_handle[b];
    heap_key[b]    = tk;
    heap_handle[b] = th;
  endfunction

  // Apply one request to the model heap and return the result it produces.
  function automatic heap_result_t apply_heap_op(input logic kind,
                                                 input logic [KEY_BITS-1:0] key,
                                                 input logic [HANDLE_BITS-1:0] handle);
    heap_result_t r;
    int unsigned  hole;
    int unsigned  up;
    int unsigned  lc;
    int unsigned  rc;
    int unsigned  pick;
    r.handle = '0;
    r.key    = '0;
    r.status = STATUS_OK;
    if (kind == KIND_INSERT) begin
      if (heap_size >= CAPACITY) begin
        r.status = STATUS_FULL;
      end else begin
        hole = heap_size;
        heap_key[hole]    = key;
        heap_handle[hole] = handle;
        heap_size++;
        // climb while strictly smaller than the parent
        while (hole > 0) begin
          up = (hole - 1) / 2;
          if (heap_key[hole] >= heap_key[up]) break;
          swap_slots(hole, up);
          hole = up;
        end
      end
    end else if (heap_size == 0) begin
      r.status = STATUS_EMPTY;
    end else begin
      r.key    = heap_key[0];
      r.handle = heap_handle[0];
      heap_size--;
      if (heap_size > 0) begin
        heap_key[0]    = heap_key[heap_size];
        heap_handle[0] = heap_handle[heap_size];
        hole = 0;
        forever begin
          lc = 2 * hole + 1;
          rc = 2 * hole + 2;
          if (lc >= heap_size) break;
          // right child wins only when strictly smaller
          pick = (rc < heap_size && heap_key[rc] < heap_key[lc]) ? rc : lc;
          if (heap_key[hole] <= heap_key[pick]) break;
          swap_slots(hole, pick);
          hole = pick;
        end
      end
    end
    r.count = COUNT_BITS'(heap_size);
    return r;
  endfunction

  always @(posedge clk) begin
    heap_result_t want;
    if (rst) begin
      heap_size = 0;
      mismatches = 0;
      pending_results.delete();
      awaiting <= 0;
    end else begin
      // retire the oldest expectation before queuing the new request
      if (rsp.valid && rsp.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending (status %0d count %0d)",
                                    rsp.status, rsp.count));
        end else begin
          want = pending_results.pop_front();
          if (rsp.out_handle !== want.handle)
            report_mismatch($sformatf("out_handle got 0x%0h want 0x%0h",
                                      rsp.out_handle, want.handle));
          if (rsp.out_key !== want.key)
            report_mismatch($sformatf("out_key got 0x%0h want 0x%0h",
                                      rsp.out_key, want.key));
          if (rsp.status !== want.status)
            report_mismatch($sformatf("status got %0d want %s",
                                      rsp.status, want.status.name()));
          if (rsp.count !== want.count)
            report_mismatch($sformatf("count got %0d want %0d", rsp.count, want.count));
        end
      end
      if (req.valid && req.ready) begin
        pending_results = {pending_results,
                           apply_heap_op(req.kind, req.key, req.node_handle)};
      end
      awaiting <= pending_results.size();
    end
  end

endmodule

// ===== dv/tb_binary_min_heap_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binary_min_heap_queue
// Drives insert and remove transactions into the min-heap queue with random
// gaps and output back-pressure; a side checker predicts every result.
// ----------------------------------------------------------------------------
module tb_binary_min_heap_queue;
  import bmhq_pkg::*;

  localparam int CAPACITY        = 256;
  localparam int KEY_BITS        = 32;
  localparam int HANDLE_BITS     = 16;
  localparam int COUNT_BITS      = 9;
  localparam int RANDOM_ITEMS    = 550;
  localparam int STALL_LIMIT     = 3000;   // well above the long hold-off below
  localparam int HOLD_OFF_AT     = 150;    // results taken before the long stall
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES    = 50;     // a bit over two worst-case sifts

  logic clk = 1'b0;
  logic rst = 1'b1;

  bmhq_in_if  #(.KEY_BITS(KEY_BITS), .HANDLE_BITS(HANDLE_BITS)) req ();
  bmhq_out_if #(.KEY_BITS(KEY_BITS), .HANDLE_BITS(HANDLE_BITS),
                .COUNT_BITS(COUNT_BITS)) rsp ();

  int mismatches;
  int awaiting;

  binary_min_heap_queue #(
    .CAPACITY   (CAPACITY),
    .KEY_BITS   (KEY_BITS),
    .HANDLE_BITS(HANDLE_BITS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  bmhq_checker #(
    .CAPACITY   (CAPACITY),
    .KEY_BITS   (KEY_BITS),
    .HANDLE_BITS(HANDLE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_checker (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .mismatches(mismatches),
    .awaiting  (awaiting)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Rough occupancy, tracked only to steer the phases toward full and empty.
  int unsigned occupancy;
  int unsigned items_sent;
  logic        tx_burst;

  // Offer one request transaction: draw a gap, present it at the falling
  // edge and hold it until the block takes it at a rising edge.
  task automatic send_item(input logic kind, input logic [KEY_BITS-1:0] key,
                           input logic [HANDLE_BITS-1:0] handle);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.valid       <= 1'b1;
    req.kind        <= kind;
    req.key         <= key;
    req.node_handle <= handle;
    do @(posedge clk); while (!req.ready);
    @(negedge clk);
    if (kind == KIND_INSERT && occupancy < CAPACITY) occupancy++;
    if (kind == KIND_REMOVE && occupancy > 0) occupancy--;
    items_sent++;
    // switch between back-to-back stretches and gappy stretches
    if (items_sent % 32 == 0) tx_burst = ($urandom_range(0, 3) == 0);
  endtask

  // Keys mix full-range values, a narrow band that forces ties, and extremes.
  function automatic logic [KEY_BITS-1:0] pick_key();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return $urandom_range(0, 15);
      7:          return ($urandom_range(0, 1) == 0) ? '0 : '1;
      default:    return {{(KEY_BITS - 4){1'b1}}, 4'($urandom_range(0, 15))};
    endcase
  endfunction

  task automatic send_random(input int unsigned insert_pct);
    logic kind;
    kind = ($urandom_range(0, 99) < insert_pct) ? KIND_INSERT : KIND_REMOVE;
    // remove transactions still carry random key and handle bits
    send_item(kind, pick_key(), HANDLE_BITS'($urandom_range(0, 65535)));
  endtask

  // Stimulus: reset, directed cases, then phases that walk the heap from
  // near empty up to full and back down.
  initial begin : request_source
    int unsigned random_sent;
    req.valid       = 1'b0;
    req.kind        = KIND_INSERT;
    req.key         = '0;
    req.node_handle = '0;
    occupancy       = 0;
    items_sent      = 0;
    tx_burst        = 1'b0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // remove on an empty heap
    send_item(KIND_REMOVE, '0, '0);
    // extremes of key and handle, plus equal keys to check tie handling
    send_item(KIND_INSERT, '1, '1);
    send_item(KIND_INSERT, '0, '0);
    send_item(KIND_INSERT, 32'h8000_0000, 16'h8000);
    send_item(KIND_INSERT, '0, 16'h1234);
    send_item(KIND_INSERT, 32'd7, 16'h0001);
    send_item(KIND_INSERT, 32'd7, 16'h0002);
    send_item(KIND_INSERT, 32'd7, 16'h0003);
    send_item(KIND_INSERT, 32'd5, 16'hAAAA);
    send_item(KIND_INSERT, 32'h5555_5555, 16'h5555);
    // drain everything in priority order
    repeat (9) send_item(KIND_REMOVE, '0, '0);
    // empty again; nonzero ignored fields must not matter
    send_item(KIND_REMOVE, '0, '0);
    send_item(KIND_REMOVE, '1, '1);

    random_sent = 0;
    // balanced traffic around a small heap, hitting empty removes
    repeat (60) begin
      send_random(50);
      random_sent++;
    end
    // fill to capacity, then push a few inserts that must be dropped
    while (occupancy < CAPACITY) begin
      send_random(90);
      random_sent++;
    end
    repeat (3) begin
      send_random(100);
      random_sent++;
    end
    // drift back down with deep sift-downs on a large heap
    while (random_sent < RANDOM_ITEMS) begin
      send_random(40);
      random_sent++;
    end
    req.valid <= 1'b0;

    // wait for every expected result, then let stray results show up
    while (awaiting != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Result side: drop ready for a random number of cycles per transaction,
  // with stretches of no stalls, and once a long hold-off so the block backs
  // up and stalls its request side.
  initial begin : result_sink
    int unsigned stall;
    int unsigned taken;
    logic        rx_burst;
    rsp.ready = 1'b0;
    taken     = 0;
    rx_burst  = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (taken == HOLD_OFF_AT) begin
        stall = HOLD_OFF_CYCLES;
      end else begin
        stall = rx_burst ? 0 : $urandom_range(0, 10);
      end
      if (stall != 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (!rsp.valid);
      @(negedge clk);
      taken++;
      if (taken % 32 == 0) rx_burst = ($urandom_range(0, 2) == 0);
    end
  end

  // Watchdog: end the run when no transaction moves on either channel for
  // too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
    $display("FAIL");
    $finish;
  end

endmodule
